// File: hdl/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
// No dependencies; used by every module under hdl/.
package wgm_pkg;

  // Default pattern capacity in bytes
  localparam int PATTERN_MAX_DEF = 32;

  // Depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // Wildcard bytes
  localparam logic [7:0] CH_ANY_ONE = 8'h3F;  // '?'
  localparam logic [7:0] CH_ANY_RUN = 8'h2A;  // '*'

  // Item kinds as carried on in_tuser
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_VALUE  = 2'd2,
    OP_END    = 2'd3
  } op_kind_t;

  // One decoded item
  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  ch;
  } op_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  // Result beat, low bit first: matched, pattern_overflow
  typedef struct packed {
    logic pattern_overflow;
    logic matched;
  } res_t;

endpackage

// File: hdl/wgm_front.sv
// Front end: accepts input beats and decodes them into queue entries.
// Depends on wgm_pkg.
module wgm_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] ch
  input  logic [1:0]    in_tuser,   // [1:0] kind
  input  logic          q_full,
  output logic          q_push,
  output wgm_pkg::op_t  q_op
);
  import wgm_pkg::*;

  op_kind_t kind;

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Classify; the byte only matters for append and value items
  always_comb begin
    kind = op_kind_t'(in_tuser);
    q_op.kind = kind;
    unique case (kind)
      OP_APPEND, OP_VALUE: q_op.ch = in_tdata;
      OP_CLEAR, OP_END:    q_op.ch = 8'h00;
      default:             q_op.ch = 8'h00;
    endcase
  end

endmodule

// File: hdl/wgm_queue.sv
// Short FIFO of decoded items between the front and back end.
// Depends on wgm_pkg.
module wgm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wgm_pkg::op_t     push_op,
  output logic             full,
  input  logic             pop,
  output wgm_pkg::q_head_t head
);
  import wgm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t               slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.op    = slot_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: hdl/wgm_back.sv
// Back end: pattern store, active position set with star closure, result register.
// Depends on wgm_pkg.
module wgm_back #(
  parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wgm_pkg::q_head_t head,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata   // [0] matched, [1] pattern_overflow
);
  import wgm_pkg::*;

  localparam int NPOS  = PATTERN_MAX + 1;
  localparam int LEN_W = $clog2(NPOS);
  localparam int LVLS  = $clog2(NPOS);

  logic [7:0]        store_r [PATTERN_MAX];
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [NPOS-1:0]   act_r, act_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_data_r;

  logic [NPOS-1:0]   gen_l [LVLS+1];
  logic [NPOS-1:0]   prp_l [LVLS+1];
  logic [NPOS-1:0]   closed;
  logic [NPOS-1:0]   step;
  logic              is_star [PATTERN_MAX];
  logic              in_pat  [PATTERN_MAX];
  logic              matched;
  logic              fire;
  logic              wr_en;

  // Per-position pattern flags
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      in_pat[i]  = (LEN_W'(i) < len_r);
      is_star[i] = in_pat[i] && (store_r[i] == CH_ANY_RUN);
    end
  end

  // Star closure as a parallel prefix: a star at p carries p into p+1
  always_comb begin
    gen_l[0]    = act_r;
    prp_l[0]    = '0;
    for (int i = 1; i < NPOS; i++) begin
      prp_l[0][i] = is_star[i-1];
    end
    for (int k = 0; k < LVLS; k++) begin
      for (int i = 0; i < NPOS; i++) begin
        if (i >= (1 << k)) begin
          gen_l[k+1][i] = gen_l[k][i] | (prp_l[k][i] & gen_l[k][i - (1 << k)]);
          prp_l[k+1][i] = prp_l[k][i] & prp_l[k][i - (1 << k)];
        end else begin
          gen_l[k+1][i] = gen_l[k][i];
          prp_l[k+1][i] = prp_l[k][i];
        end
      end
    end
    closed = gen_l[LVLS];
  end

  // One value byte against every live position
  always_comb begin
    step = '0;
    for (int p = 0; p < PATTERN_MAX; p++) begin
      if (closed[p] && in_pat[p]) begin
        if (store_r[p] == CH_ANY_RUN) begin
          step[p] = 1'b1;
        end else if (store_r[p] == CH_ANY_ONE || store_r[p] == head.op.ch) begin
          step[p+1] = 1'b1;
        end
      end
    end
  end

  assign matched = closed[len_r];

  // End items wait for a free result slot; others never stall
  assign pop  = head.valid &&
                (head.op.kind != OP_END || !out_valid_r || out_tready);
  assign fire = pop;

  // Next-state for matcher state and result slot
  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    act_nxt       = act_r;
    wr_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    if (fire) begin
      unique case (head.op.kind)
        OP_CLEAR: begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
          act_nxt = NPOS'(1);
        end
        OP_APPEND: begin
          if (len_r < LEN_W'(PATTERN_MAX)) begin
            wr_en   = 1'b1;
            len_nxt = len_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_VALUE: begin
          act_nxt = step;
        end
        OP_END: begin
          act_nxt       = NPOS'(1);
          out_valid_nxt = 1'b1;
        end
        default: begin
          act_nxt = act_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      act_r       <= NPOS'(1);
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pattern bytes and result payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (wr_en && len_r == LEN_W'(i)) begin
        store_r[i] <= head.op.ch;
      end
    end
    if (fire && head.op.kind == OP_END) begin
      out_data_r.matched          <= matched;
      out_data_r.pattern_overflow <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

endmodule

// File: hdl/wildcard_glob_matcher_top.sv
// Top level of the wildcard glob matcher: front end, item queue, back end.
// Depends on wgm_pkg, wgm_front, wgm_queue, wgm_back.
//
//  channel | dir | tdata                               | tuser     | notes
//  in_     | in  | [7:0] ch                            | [1:0] kind| one beat per item
//  out_    | out | [0] matched, [1] pattern_overflow   | -         | one beat per end item
//
// One item per cycle sustained unless an end item waits on out_tready; each item is
// handled in a single back-end pass, as the closure prefix network and per-position
// compare are combinational. End results go through the queue, then a result register.
// Synchronous active-low reset empties the pattern and the queue.
// Only end items wait on out_tready; when the queue fills, in_tready drops.
module wildcard_glob_matcher_top #(
  parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] ch
  input  logic [1:0]  in_tuser,    // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata    // [0] matched, [1] pattern_overflow
);
  import wgm_pkg::*;

  logic     q_full;
  logic     q_push;
  op_t      q_op;
  logic     q_pop;
  q_head_t  q_head;

  wgm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (q_op)
  );

  wgm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head)
  );

  wgm_back #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
